// File: rtl/pei_pkg.sv
`timescale 1ns / 1ps
package pei_pkg;

   // Fixed-point bases of the log and exp tables
   localparam int LB = 24;
   localparam int EB = 30;

   // Opcodes carried in the input transaction
   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_BEGIN    = 3'd1;
   localparam logic [2:0] OP_PAUSE    = 3'd2;
   localparam logic [2:0] OP_CONTINUE = 3'd3;
   localparam logic [2:0] OP_STOP     = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] CSR_START    = 3'd0;
   localparam logic [2:0] CSR_TARGET   = 3'd1;
   localparam logic [2:0] CSR_MODE     = 3'd2;
   localparam logic [2:0] CSR_EXPONENT = 3'd3;
   localparam logic [2:0] CSR_DURATION = 3'd4;

   // Curve modes
   localparam logic [1:0] MODE_IN     = 2'd0;
   localparam logic [1:0] MODE_OUT    = 2'd1;
   localparam logic [1:0] MODE_IN_OUT = 2'd2;
   localparam logic [1:0] MODE_HOLD   = 2'd3;

   // Reset values of the configuration registers
   localparam logic [1:0]  RST_MODE     = MODE_OUT;
   localparam logic [15:0] RST_EXPONENT = 16'd512;
   localparam logic [31:0] RST_DURATION = 32'd65536;

   // Integer square root, used to build the exp2 table
   function automatic logic [63:0] isqrt64(input logic [63:0] n_arg);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bit_v;
      n     = n_arg;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (bit_v > n) bit_v = bit_v >> 2;
      end
      for (int j = 0; j < 32; j++) begin
         if (bit_v != 64'd0) begin
            if (n >= res + bit_v) begin
               n   = n - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // log2 of v in [2^30, 2^31) by repeated squaring, Q.24 result
   function automatic logic [31:0] log2_exact(input logic [63:0] v);
      logic [63:0] y;
      logic [31:0] r;
      y = v;
      r = '0;
      for (int b = LB - 1; b >= 0; b--) begin
         y = (y * y) >> EB;
         if (y >= (64'd1 << (EB + 1))) begin
            y    = y >> 1;
            r[b] = 1'b1;
         end
      end
      return r;
   endfunction

   // 2^h for h in [0,1) as Q.24, product of square roots of two, Q.30 result
   function automatic logic [31:0] exp2_exact(input logic [63:0] h);
      logic [63:0] prod;
      logic [63:0] c;
      prod = 64'd1 << EB;
      c    = isqrt64(64'd1 << (2 * EB + 1));
      for (int k = 1; k <= LB; k++) begin
         if (h[LB - k]) prod = (prod * c) >> EB;
         c = isqrt64(c << EB);
      end
      return prod[31:0];
   endfunction

endpackage

// File: rtl/pei_div.sv
`timescale 1ns / 1ps
module pei_div #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              dividend,
   input  logic [31:0]              divisor,
   output logic                     done,
   output logic [FRACTION_BITS:0]   quotient
);
   localparam int NW = 32 + FRACTION_BITS;
   localparam int CW = $clog2(NW + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [NW-1:0]     num_ff;
   logic [31:0]       rem_ff;
   logic [31:0]       den_ff;
   logic [FRACTION_BITS:0] quo_ff;

   logic [32:0]       trial_in;
   logic              fits_in;
   logic [31:0]       rem_in;

   // One restoring step: shift in a numerator bit, subtract if it fits
   always_comb begin
      trial_in = {rem_ff, num_ff[NW-1]};
      fits_in  = trial_in >= {1'b0, den_ff};
      rem_in   = fits_in ? 32'(trial_in - {1'b0, den_ff}) : trial_in[31:0];
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= NW'(dividend) << FRACTION_BITS;
         rem_ff <= '0;
         den_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[FRACTION_BITS-1:0], fits_in};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: rtl/pei_mul.sv
`timescale 1ns / 1ps
module pei_mul #(
   parameter int BW = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [32:0]       mcand,
   input  logic [BW-1:0]     mplier,
   output logic              done,
   output logic [32+BW:0]    product
);
   localparam int PW = 33 + BW;
   localparam int CW = $clog2(BW + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [32:0]       mcand_ff;
   logic [PW-1:0]     acc_ff;
   logic [33:0]       sum_in;

   // Add the multiplicand when the low multiplier bit is set
   assign sum_in = {1'b0, acc_ff[PW-1:BW]} + (acc_ff[0] ? {1'b0, mcand_ff} : 34'd0);

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(BW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift-add datapath, one multiplier bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mcand;
         acc_ff   <= PW'(mplier);
      end else if (busy_ff) begin
         acc_ff <= {sum_in, acc_ff[BW-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// File: rtl/pei_rom.sv
`timescale 1ns / 1ps
module pei_rom #(
   parameter int LOG_TABLE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 sel_exp,
   input  logic [$clog2(LOG_TABLE_DEPTH+1)-1:0] addr,
   output logic [31:0]                          rd_data
);
   import pei_pkg::*;

   logic [31:0] log_rom [0:LOG_TABLE_DEPTH];
   logic [31:0] exp_rom [0:LOG_TABLE_DEPTH];
   logic [31:0] rd_data_ff;

   // Build both tables at elaboration
   for (genvar gi = 0; gi <= LOG_TABLE_DEPTH; gi++) begin : g_entry
      localparam logic [63:0] LX = (64'(gi) << EB) / LOG_TABLE_DEPTH;
      localparam logic [63:0] HX = (64'(gi) << LB) / LOG_TABLE_DEPTH;
      assign log_rom[gi] = (gi == LOG_TABLE_DEPTH) ? (32'd1 << LB)
                                                   : log2_exact((64'd1 << EB) + LX);
      assign exp_rom[gi] = (gi == LOG_TABLE_DEPTH) ? (32'd1 << (EB + 1))
                                                   : exp2_exact(HX);
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= sel_exp ? exp_rom[addr] : log_rom[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/power_ease_interpolator.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tuser opcode, tdata delta_time
// rsp      out        rsp_tvalid/rsp_tready   tdata value, playing
// csr      in         csr_valid/csr_ready     csr_index, csr_data
//
// Opcodes other than a playing tick go straight from idle to the response state.
// A playing tick runs the bit-serial divider and up to four passes of the shift-add
// multiplier before its response. Mode three skips the curve and goes straight to
// the response state.
// Reset is synchronous and restores the registers to their documented values.
// A new transaction is taken while a finished result waits in the output register.
module power_ease_interpolator #(
   parameter int FRACTION_BITS   = 16,
   parameter int LOG_TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [19:0] delta_time
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] value, [32] playing
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import pei_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int TW = F + 1;
   localparam int BW = (F + 1 > LB) ? F + 1 : LB;
   localparam int PW = 33 + BW;
   localparam int KW = PW - 32;
   localparam int AW = $clog2(LOG_TABLE_DEPTH + 1);
   localparam int SW = $clog2(F + 1);
   localparam logic [TW-1:0] ONE  = TW'(1) << F;
   localparam logic [TW-1:0] HALF = ONE >> 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RESP = 4'd1;
   localparam logic [3:0] S_DIV  = 4'd2;
   localparam logic [3:0] S_PW0  = 4'd3;
   localparam logic [3:0] S_NORM = 4'd4;
   localparam logic [3:0] S_LIDX = 4'd5;
   localparam logic [3:0] S_LA   = 4'd6;
   localparam logic [3:0] S_LB   = 4'd7;
   localparam logic [3:0] S_LC   = 4'd8;
   localparam logic [3:0] S_LMUL = 4'd9;
   localparam logic [3:0] S_EMUL = 4'd10;
   localparam logic [3:0] S_MIX  = 4'd11;
   localparam logic [3:0] S_VMUL = 4'd12;

   // Configuration and state
   logic [31:0] start_ff, target_ff, dur_ff, el_ff, current_ff;
   logic [1:0]  mode_ff;
   logic [15:0] exponent_ff;
   logic        playing_ff;
   logic [3:0]  state_ff;

   // Working registers
   logic [TW-1:0] x_ff, pw_ff;
   logic          inv_ff, halve_ff, phase_exp_ff, dir_ff, neg_ff;
   logic [SW-1:0] s_ff;
   logic [LB-1:0] f24_ff, r_ff;
   logic [AW-1:0] addr_ff;
   logic [31:0]   ta_ff;
   logic [KW-1:0] k_ff;

   // Output register
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   logic req_fire, rsp_fire, csr_fire, rsp_load;
   logic [32:0] sum_el;
   logic [31:0] el_in;
   logic        div_start, div_done;
   logic [TW-1:0] div_quot;
   logic        mul_start, mul_done;
   logic [32:0] mul_a;
   logic [BW-1:0] mul_b;
   logic [PW-1:0] mul_prod;
   logic [31:0] rom_data;
   logic [TW-1:0] x_in;
   logic        inv_in, halve_in;
   logic [LB+AW-1:0] lk_idx;
   logic        dir_in;
   logic [31:0] diff_in, lv_in;
   logic [32:0] nl_in;
   logic [KW-1:0] k_in;
   logic [LB-1:0] g_in;
   logic [KW:0] sh_in;
   logic [TW-1:0] pw_ex_in, p_sel, p_in;
   logic [32:0] dx_in, mag_in;
   logic [PW:0] sp_in, q_in;
   logic [31:0] value_in;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_load   = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   pei_div #(.FRACTION_BITS(F)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(el_in), .divisor(dur_ff), .done(div_done), .quotient(div_quot)
   );

   pei_mul #(.BW(BW)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .mcand(mul_a), .mplier(mul_b), .done(mul_done), .product(mul_prod)
   );

   pei_rom #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_rom (
      .clock(clock), .sel_exp(phase_exp_ff), .addr(addr_ff), .rd_data(rom_data)
   );

   // Advance elapsed time, saturating at the duration
   always_comb begin
      sum_el = 33'(el_ff) + 33'(req_tdata[19:0]);
      if (el_ff < dur_ff) el_in = (sum_el > 33'(dur_ff)) ? dur_ff : sum_el[31:0];
      else                el_in = dur_ff;
   end

   assign div_start = (state_ff == S_IDLE) && req_fire && (req_tuser == OP_TICK)
                      && playing_ff && (mode_ff != MODE_HOLD);

   // Fold the curve mode into the power argument
   always_comb begin
      x_in     = div_quot;
      inv_in   = 1'b0;
      halve_in = 1'b0;
      case (mode_ff)
         MODE_IN: x_in = div_quot;
         MODE_OUT: begin
            x_in   = ONE - div_quot;
            inv_in = 1'b1;
         end
         MODE_IN_OUT: begin
            halve_in = 1'b1;
            if (div_quot <= HALF) begin
               x_in = div_quot << 1;
            end else begin
               x_in   = (ONE - div_quot) << 1;
               inv_in = 1'b1;
            end
         end
         default: x_in = div_quot;
      endcase
   end

   // Table lookup and interpolation arithmetic
   always_comb begin
      lk_idx  = (LB+AW)'(f24_ff) * (LB+AW)'(LOG_TABLE_DEPTH);
      dir_in  = rom_data >= ta_ff;
      diff_in = dir_in ? rom_data - ta_ff : ta_ff - rom_data;
      lv_in   = dir_ff ? ta_ff + mul_prod[LB+31:LB] : ta_ff - mul_prod[LB+31:LB];
      nl_in   = (33'(s_ff) << LB) - 33'(lv_in);
      k_in    = mul_prod[PW-1:32];
      g_in    = mul_prod[LB+7:8];
      sh_in   = (KW+1)'(31 - F) + (KW+1)'(k_ff);
      pw_ex_in = (sh_in >= (KW+1)'(32)) ? '0 : TW'(lv_in >> sh_in[4:0]);
   end

   // Blend start and target by the eased fraction
   always_comb begin
      p_sel    = halve_ff ? (pw_ff >> 1) : pw_ff;
      p_in     = inv_ff ? ONE - p_sel : p_sel;
      dx_in    = {target_ff[31], target_ff} - {start_ff[31], start_ff};
      mag_in   = dx_in[32] ? 33'(-dx_in) : dx_in;
      sp_in    = neg_ff ? -{1'b0, mul_prod} : {1'b0, mul_prod};
      q_in     = $signed(sp_in) >>> F;
      value_in = start_ff + q_in[31:0];
   end

   // Multiplier operands by sequencer step
   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_LC: begin
            mul_start = 1'b1;
            mul_a     = 33'(diff_in);
            mul_b     = BW'(r_ff);
         end
         S_LMUL: begin
            if (mul_done && !phase_exp_ff) begin
               mul_start = 1'b1;
               mul_a     = nl_in;
               mul_b     = BW'(exponent_ff);
            end
         end
         S_MIX: begin
            mul_start = 1'b1;
            mul_a     = mag_in;
            mul_b     = BW'(p_in);
         end
         default: mul_start = 1'b0;
      endcase
   end

   // Sequencer, configuration and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         target_ff    <= '0;
         mode_ff      <= RST_MODE;
         exponent_ff  <= RST_EXPONENT;
         dur_ff       <= RST_DURATION;
         playing_ff   <= 1'b0;
         el_ff        <= '0;
         current_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Load a finished result, or drop the one just taken
         if (rsp_load)      rsp_valid_ff <= 1'b1;
         else if (rsp_fire) rsp_valid_ff <= 1'b0;

         if (csr_fire) begin
            case (csr_index)
               CSR_START: begin
                  start_ff   <= csr_data;
                  current_ff <= csr_data;
               end
               CSR_TARGET: begin
                  target_ff  <= csr_data;
                  current_ff <= start_ff;
               end
               CSR_MODE:     mode_ff     <= csr_data[1:0];
               CSR_EXPONENT: exponent_ff <= csr_data[15:0];
               CSR_DURATION: dur_ff      <= (csr_data == 32'd0) ? 32'd1 : csr_data;
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= div_start ? S_DIV : S_RESP;
                  case (req_tuser)
                     OP_TICK: begin
                        if (playing_ff) begin
                           el_ff <= el_in;
                           if (el_ff >= dur_ff) playing_ff <= 1'b0;
                        end
                     end
                     OP_BEGIN: begin
                        el_ff      <= '0;
                        playing_ff <= 1'b1;
                     end
                     OP_PAUSE:    playing_ff <= 1'b0;
                     OP_CONTINUE: playing_ff <= 1'b1;
                     OP_STOP: begin
                        el_ff      <= '0;
                        playing_ff <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            S_DIV: begin
               if (div_done) begin
                  x_ff     <= x_in;
                  inv_ff   <= inv_in;
                  halve_ff <= halve_in;
                  state_ff <= S_PW0;
               end
            end
            S_PW0: begin
               if (exponent_ff == 16'd0 || x_ff[F]) begin
                  pw_ff    <= ONE;
                  state_ff <= S_MIX;
               end else if (x_ff == '0) begin
                  pw_ff    <= '0;
                  state_ff <= S_MIX;
               end else begin
                  s_ff     <= '0;
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (x_ff[F]) begin
                  f24_ff       <= LB'(x_ff[F-1:0]) << (LB - F);
                  phase_exp_ff <= 1'b0;
                  state_ff     <= S_LIDX;
               end else begin
                  x_ff <= x_ff << 1;
                  s_ff <= s_ff + SW'(1);
               end
            end
            S_LIDX: begin
               addr_ff  <= lk_idx[LB+AW-1:LB];
               r_ff     <= lk_idx[LB-1:0];
               state_ff <= S_LA;
            end
            S_LA: begin
               addr_ff  <= addr_ff + AW'(1);
               state_ff <= S_LB;
            end
            S_LB: begin
               ta_ff    <= rom_data;
               state_ff <= S_LC;
            end
            S_LC: begin
               dir_ff   <= dir_in;
               state_ff <= S_LMUL;
            end
            S_LMUL: begin
               if (mul_done) begin
                  if (phase_exp_ff) begin
                     pw_ff    <= pw_ex_in;
                     state_ff <= S_MIX;
                  end else begin
                     state_ff <= S_EMUL;
                  end
               end
            end
            S_EMUL: begin
               if (mul_done) begin
                  if (g_in == '0) begin
                     pw_ff    <= (k_in > KW'(F)) ? '0 : (ONE >> k_in);
                     state_ff <= S_MIX;
                  end else begin
                     k_ff         <= k_in;
                     f24_ff       <= LB'(0) - g_in;
                     phase_exp_ff <= 1'b1;
                     state_ff     <= S_LIDX;
                  end
               end
            end
            S_MIX: begin
               neg_ff   <= dx_in[32];
               state_ff <= S_VMUL;
            end
            S_VMUL: begin
               if (mul_done) begin
                  current_ff <= value_in;
                  state_ff   <= S_RESP;
               end
            end
            S_RESP: begin
               if (rsp_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Load the output transaction
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {7'd0, playing_ff, current_ff};
      end
   end
endmodule

// File: rtl/pei_checker.sv
`timescale 1ns / 1ps
module pei_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import pei_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

   // Drop the result channel after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Report playing after a begin on an empty output, via the response state and output register
   a_begin_plays: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_BEGIN && !rsp_tvalid
      |-> ##2 (rsp_tvalid && rsp_tdata[32]))
      else $error("begin did not report playing");

   // Report stopped after a stop on an empty output, via the response state and output register
   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_STOP && !rsp_tvalid
      |-> ##2 (rsp_tvalid && !rsp_tdata[32]))
      else $error("stop did not report stopped");
endmodule

bind power_ease_interpolator pei_checker u_pei_checker (.*);

// File: test/power_ease_checker.sv
`timescale 1ns / 1ps
module power_ease_checker
   import pei_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [19:0] delta_time
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] value, [32] playing
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatches,
   output int          outstanding
);

   localparam int FB    = 16;
   localparam int DEPTH = 256;
   localparam longint unsigned ONE = 64'd1 << FB;

   typedef struct packed {
      logic [31:0] value;
      logic        playing;
   } ease_out_t;

   // Curve tables: log2 mantissa (Q.24) and exp2 fraction (Q2.30)
   logic [31:0] log_lut [0:DEPTH];
   logic [31:0] exp_lut [0:DEPTH];

   // Shadow configuration and state
   logic [31:0]       start_q, target_q, dur_q;
   logic [1:0]        mode_q;
   logic [15:0]       expo_q;
   logic              play_q;
   longint unsigned   elapsed_q;
   logic [31:0]       value_q;
   ease_out_t         results_due [$];

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned r, cand;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         if (cand * cand <= n) r = cand;
      end
      return r;
   endfunction

   function automatic logic [31:0] mant_log2(input longint unsigned v);
      longint unsigned y;
      logic [31:0] acc;
      y   = v;
      acc = '0;
      for (int b = LB - 1; b >= 0; b--) begin
         y = (y * y) >> EB;
         if (y >= (64'd1 << (EB + 1))) begin
            y      = y >> 1;
            acc[b] = 1'b1;
         end
      end
      return acc;
   endfunction

   function automatic logic [31:0] frac_exp2(input longint unsigned h);
      longint unsigned prod, c;
      prod = 64'd1 << EB;
      c    = root_floor(64'd1 << (2 * EB + 1));
      for (int k = 1; k <= LB; k++) begin
         if ((h >> (LB - k)) & 1) prod = (prod * c) >> EB;
         c = root_floor(c << EB);
      end
      return prod[31:0];
   endfunction

   // Linear interpolation between neighboring table entries
   function automatic longint unsigned interp(input bit use_exp, input longint unsigned f,
                                              input int s);
      longint unsigned idx, i, r, a, b;
      idx = f * DEPTH;
      i   = idx >> s;
      r   = idx & ((64'd1 << s) - 1);
      if (i >= DEPTH) return use_exp ? exp_lut[DEPTH] : log_lut[DEPTH];
      a = use_exp ? exp_lut[i] : log_lut[i];
      b = use_exp ? exp_lut[i + 1] : log_lut[i + 1];
      if (b >= a) return a + (((b - a) * r) >> s);
      return a - (((a - b) * r) >> s);
   endfunction

   // x^a as 2^(a * log2 x), x in Q1.16, a in Q8.8
   function automatic longint unsigned raise_pow(input longint unsigned x,
                                                 input logic [15:0] a);
      longint unsigned xn, nl, e, k, g, ex, sh;
      int m;
      if (a == 0 || x >= ONE) return ONE;
      if (x == 0) return 0;
      m = FB - 1;
      while (((x >> m) & 1) == 0) m--;
      xn = x << (FB - m);
      nl = (longint'(FB - m) << LB) - interp(1'b0, xn - ONE, FB);
      e  = (nl * a) >> 8;
      k  = e >> LB;
      g  = e & ((64'd1 << LB) - 1);
      if (g == 0) return (k > FB) ? 0 : (ONE >> k);
      ex = interp(1'b1, (64'd1 << LB) - g, LB);
      sh = (EB - FB) + k + 1;
      return (sh >= 63) ? 0 : (ex >> sh);
   endfunction

   // Advance elapsed time and re-evaluate the eased value
   function automatic void advance(input longint unsigned dt);
      longint unsigned t, p;
      longint dx, prod, q;
      if (elapsed_q < dur_q) begin
         elapsed_q = elapsed_q + dt;
         if (elapsed_q > dur_q) elapsed_q = dur_q;
      end else begin
         elapsed_q = dur_q;
         play_q    = 1'b0;
      end
      t = (elapsed_q << FB) / dur_q;
      case (mode_q)
         MODE_IN:  p = raise_pow(t, expo_q);
         MODE_OUT: p = ONE - raise_pow(ONE - t, expo_q);
         MODE_IN_OUT: begin
            if (t <= (ONE >> 1)) p = raise_pow(2 * t, expo_q) >> 1;
            else p = ONE - (raise_pow(2 * (ONE - t), expo_q) >> 1);
         end
         default: return;
      endcase
      dx      = longint'(signed'(target_q)) - longint'(signed'(start_q));
      prod    = dx * longint'(p);
      q       = prod >>> FB;
      value_q = 32'(longint'(signed'(start_q)) + q);
   endfunction

   function automatic ease_out_t predict_ease(input logic [2:0] op, input logic [19:0] dt);
      ease_out_t r;
      case (op)
         OP_TICK:     if (play_q) advance(dt);
         OP_BEGIN:    begin elapsed_q = 0; play_q = 1'b1; end
         OP_PAUSE:    play_q = 1'b0;
         OP_CONTINUE: play_q = 1'b1;
         OP_STOP:     begin play_q = 1'b0; elapsed_q = 0; end
         default:     ;
      endcase
      r.value   = value_q;
      r.playing = play_q;
      return r;
   endfunction

   // Build the curve tables once
   initial begin
      for (int i = 0; i <= DEPTH; i++) begin
         if (i == DEPTH) begin
            log_lut[i] = 32'd1 << LB;
            exp_lut[i] = 32'd1 << (EB + 1);
         end else begin
            log_lut[i] = mant_log2((64'd1 << EB) + ((longint'(i) << EB) / DEPTH));
            exp_lut[i] = frac_exp2((longint'(i) << LB) / DEPTH);
         end
      end
   end

   assign outstanding = results_due.size();

   // Watch all three channels; compare the oldest expectation first
   always @(posedge clock) begin
      ease_out_t want;
      if (reset) begin
         start_q    = '0;
         target_q   = '0;
         mode_q     = RST_MODE;
         expo_q     = RST_EXPONENT;
         dur_q      = RST_DURATION;
         play_q     = 1'b0;
         elapsed_q  = 0;
         value_q    = '0;
         mismatches = 0;
         results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $error("unexpected result transaction: value %h playing %b",
                      rsp_tdata[31:0], rsp_tdata[32]);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata[31:0] !== want.value) begin
                  $error("value: expected %h, actual %h", want.value, rsp_tdata[31:0]);
                  mismatches++;
               end
               if (rsp_tdata[32] !== want.playing) begin
                  $error("playing: expected %b, actual %b", want.playing, rsp_tdata[32]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            results_due.push_back(predict_ease(req_tuser, req_tdata[19:0]));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START:    begin start_q = csr_data; value_q = csr_data; end
               CSR_TARGET:   begin target_q = csr_data; value_q = start_q; end
               CSR_MODE:     mode_q = csr_data[1:0];
               CSR_EXPONENT: expo_q = csr_data[15:0];
               CSR_DURATION: dur_q = (csr_data == 0) ? 32'd1 : csr_data;
               default:      ;
            endcase
         end
      end
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
   import pei_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [19:0] delta_time
   logic [2:0]  req_tuser;   // [2:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] value, [32] playing
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   int          mismatches;
   int          outstanding;

   bit          calm;
   int          hold_req, hold_done;
   int          sent, writes;
   logic [31:0] cur_dur;

   power_ease_interpolator uut (.*);

   power_ease_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_valid, .csr_ready,
      .csr_index, .csr_data, .mismatches, .outstanding
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", outstanding);
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 0;
      hold_done  = 0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_done) begin
            hold_done = hold_req;
            rsp_tready <= 0;
            repeat (600) @(negedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_tready <= 1;
      end
   end

   // Offer one transaction and hold it until accepted
   task automatic send_op(input logic [2:0] op, input logic [19:0] dt);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, dt};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   // Drain every expected result
   task automatic drain();
      req_tvalid <= 0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
      if (idx == CSR_DURATION) cur_dur = val;
      writes++;
   endtask

   function automatic logic [31:0] pick_wide();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Step size that lets an animation end in a few dozen ticks
   function automatic logic [19:0] pick_step();
      logic [31:0] s;
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 20'hFFFFF);
         1:       return 20'hFFFFF;
         2:       return 0;
         default: begin
            s = cur_dur / $urandom_range(3, 40);
            return (s > 32'hFFFFF) ? 20'hFFFFF : s[19:0];
         end
      endcase
   endfunction

   task automatic random_setup();
      logic [31:0] d;
      write_reg(CSR_START, pick_wide());
      write_reg(CSR_TARGET, pick_wide());
      write_reg(CSR_MODE, ($urandom_range(0, 9) == 0) ? 32'(MODE_HOLD) : $urandom_range(0, 2));
      case ($urandom_range(0, 7))
         0:       write_reg(CSR_EXPONENT, 0);
         1:       write_reg(CSR_EXPONENT, 16'hFFFF);
         2:       write_reg(CSR_EXPONENT, $urandom_range(0, 16'hFFFF));
         default: write_reg(CSR_EXPONENT, $urandom_range(1, 16'h0800));
      endcase
      case ($urandom_range(0, 9))
         0:       d = 1;
         1:       d = 32'hFFFF_FFFF;
         2:       d = $urandom_range(1, 255);
         default: d = $urandom_range(256, 32'h20_0000);
      endcase
      write_reg(CSR_DURATION, d);
      if ($urandom_range(0, 3) == 0) write_reg(3'd5 + 3'($urandom_range(0, 2)), $urandom);
   endtask

   // One animation: begin, ticks, with occasional control noise
   task automatic play_run(input int n);
      send_op(OP_BEGIN, $urandom_range(0, 20'hFFFFF));
      for (int i = 1; i < n; i++) begin
         case ($urandom_range(0, 19))
            0:       send_op(OP_PAUSE, $urandom_range(0, 20'hFFFFF));
            1:       send_op(OP_CONTINUE, $urandom_range(0, 20'hFFFFF));
            2:       send_op(OP_STOP, $urandom_range(0, 20'hFFFFF));
            3:       send_op(3'($urandom_range(5, 7)), $urandom_range(0, 20'hFFFFF));
            4:       send_op(OP_BEGIN, $urandom_range(0, 20'hFFFFF));
            default: send_op(OP_TICK, pick_step());
         endcase
      end
   endtask

   initial begin
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = OP_TICK;
      csr_valid  = 0;
      csr_index  = CSR_START;
      csr_data   = '0;
      calm       = 0;
      hold_req   = 0;
      sent       = 0;
      writes     = 0;
      cur_dur    = RST_DURATION;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: defaults, stopped tick, pause/continue, end reached, bad opcodes
      send_op(OP_TICK, 20'h12345);
      send_op(OP_BEGIN, 0);
      send_op(OP_TICK, 0);
      send_op(OP_TICK, 20'h08000);
      send_op(OP_PAUSE, 0);
      send_op(OP_TICK, 20'h04000);
      send_op(OP_CONTINUE, 0);
      send_op(OP_TICK, 20'hFFFFF);
      send_op(OP_TICK, 20'h00001);
      send_op(OP_STOP, 0);
      send_op(3'd5, 20'hFFFFF);
      send_op(3'd6, 0);
      send_op(3'd7, 20'hAAAAA);
      // Full-range swing, ease-in with zero then maximal exponent, then ease-in-out
      write_reg(CSR_START, 32'h8000_0000);
      write_reg(CSR_TARGET, 32'h7FFF_FFFF);
      write_reg(CSR_MODE, MODE_IN);
      write_reg(CSR_EXPONENT, 0);
      send_op(OP_BEGIN, 0);
      send_op(OP_TICK, 20'h05555);
      write_reg(CSR_EXPONENT, 16'hFFFF);
      send_op(OP_TICK, 20'h0AAAA);
      write_reg(CSR_MODE, MODE_IN_OUT);
      write_reg(CSR_EXPONENT, 16'h0180);
      send_op(OP_TICK, 20'h01000);
      send_op(OP_TICK, 20'h04000);
      // Hold mode, then duration zero, a shrunk duration and an unused register
      write_reg(CSR_MODE, MODE_HOLD);
      send_op(OP_TICK, 20'h02000);
      write_reg(CSR_MODE, MODE_OUT);
      write_reg(CSR_DURATION, 0);
      send_op(OP_BEGIN, 0);
      send_op(OP_TICK, 0);
      write_reg(CSR_DURATION, 32'h0001_0000);
      send_op(OP_BEGIN, 0);
      send_op(OP_TICK, 20'h0C000);
      write_reg(CSR_DURATION, 32'h0000_4000);
      send_op(OP_TICK, 20'h00010);
      write_reg(3'd7, 32'hDEAD_BEEF);
      send_op(OP_TICK, 20'h00010);

      // Random phases; one with a long receiver hold-off, one with a sender pause
      for (int ph = 0; ph < 12; ph++) begin
         random_setup();
         if (ph == 11) calm = 1;
         if (ph == 4) hold_req++;
         while (sent < 45 + (ph + 1) * 85) begin
            play_run($urandom_range(4, 40));
            if (ph == 7 && $urandom_range(0, 2) == 0) drain();
         end
      end

      drain();
      repeat (400) @(posedge clock);
      $display("Covered %0d transactions and %0d register writes: all curve modes,",
               sent, writes);
      $display("exponent and duration extremes, control opcodes and back-pressure.");
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
